// ----- hdl/cobs_crc_frame_receiver_macros.svh -----
// Assertion helpers for the frame receiver checker.
`ifndef COBS_CRC_FRAME_RECEIVER_MACROS_SVH
`define COBS_CRC_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, masked while rst is high.
`define CCFR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccfr assertion failed");

// Next-cycle implication, masked while rst is high.
`define CCFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccfr assertion failed");

`endif

// ----- hdl/ccfr_pkg.sv -----
`timescale 1ns / 1ps
package ccfr_pkg;

  localparam int RAW_CAPACITY_DEF   = 260;
  localparam int FRAME_CAPACITY_DEF = 257;
  localparam int CMP_W              = 12;  // covers counts up to 1024 plus a byte

  localparam logic       OP_FEED = 1'b0;
  localparam logic       OP_READ = 1'b1;

  localparam logic [1:0] STAT_NEED_MORE = 2'd0;
  localparam logic [1:0] STAT_IDLE      = 2'd1;
  localparam logic [1:0] STAT_DROP      = 2'd2;
  localparam logic [1:0] STAT_READY     = 2'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_USE,
    S_FINISH,
    S_RESULT
  } ccfr_state_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/cobs_crc_frame_receiver.sv -----
`timescale 1ns / 1ps
// COBS frame receiver with CRC-16/CCITT-FALSE check.
// Input channel (in_valid/in_ready): one beat carries opcode, wire_byte, read_index.
//   opcode feed: wire_byte is a link byte; nonzero bytes go to the raw buffer,
//   a zero byte closes the frame and starts the decode/check walk.
//   opcode read: returns the committed frame byte at read_index (0 past length).
// Output channel (out_valid/out_ready): exactly one beat per input beat, in order,
//   with status, frame_length (committed length) and read_data.
// A nonzero feed or a read goes from idle straight to the result state, which loads
//   the output register once the slot is free; in_ready returns at that same edge.
//   A delimiter walks each stored raw byte through fetch (one raw RAM read) and use
//   (one decode step through the CRC unit), then goes through finish to result; a run
//   that overruns the frame cuts it short; overflowed or empty frames skip the walk.
//   Throughput: one item at a time; in_ready is high only between items.
// Decoded bytes land in the staging half of a two-bank frame RAM; a good frame
//   commits by flipping the bank select, so a dropped frame leaves the old one intact.
// Reset (rst, synchronous) empties the raw buffer, clears overflow and the
//   committed length, drops any pending output beat and holds in_ready low.
// If the receiver stalls, the result beat holds in the output register; one more
//   input beat may be accepted and worked, then the block waits for the slot.
module cobs_crc_frame_receiver #(
  parameter int RAW_CAPACITY   = ccfr_pkg::RAW_CAPACITY_DEF,
  parameter int FRAME_CAPACITY = ccfr_pkg::FRAME_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       opcode,
  input  logic [7:0] wire_byte,
  input  logic [8:0] read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [8:0] frame_length,
  output logic [7:0] read_data
);

  localparam int RAW_AW   = $clog2(RAW_CAPACITY);
  localparam int RAW_CW   = $clog2(RAW_CAPACITY + 1);
  localparam int FRM_DEPTH = 2 * FRAME_CAPACITY;
  localparam int FRM_AW   = $clog2(FRM_DEPTH);
  localparam int CW       = ccfr_pkg::CMP_W;

  ccfr_pkg::ccfr_state_t state, state_next;

  // control state
  logic [RAW_CW-1:0] raw_count;
  logic              overflow;
  logic [8:0]        committed_length;
  logic              bank;           // bank holding the committed frame

  // decode walk
  logic [RAW_CW-1:0] pos;
  logic [RAW_CW-1:0] dcount;         // decoded bytes so far
  logic [7:0]        remain;         // data bytes left in current run
  logic              first;
  logic              code_ff;
  logic [7:0]        len_r;
  logic [15:0]       got_crc;

  // pending result
  logic [1:0] pend_status;
  logic       pend_read;
  logic       pend_hit;

  // RAM / unit hookups
  logic              raw_we, raw_re;
  logic [7:0]        raw_rdata;
  logic              frm_we, frm_re;
  logic [FRM_AW-1:0] frm_waddr, frm_raddr;
  logic [7:0]        frm_rdata;
  logic              crc_init, crc_en;
  logic [15:0]       crc;

  logic       accept;
  logic       is_code, run_over, last_byte, emit, in_crc, fin_ok, slot_free;
  logic [7:0] emit_byte;
  logic [CW-1:0] len_w, dcount_w, fa_w, ra_w;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == ccfr_pkg::S_IDLE) && !rst;
  assign slot_free = !out_valid || out_ready;

  assign len_w    = CW'(len_r);
  assign dcount_w = CW'(dcount);
  assign is_code   = (remain == 8'd0);
  assign run_over  = (CW'(pos) + CW'(raw_rdata)) > CW'(raw_count);
  assign last_byte = (CW'(pos) + CW'(1)) == CW'(raw_count);
  assign emit_byte = is_code ? 8'h00 : raw_rdata;
  assign in_crc    = (dcount_w < CW'(2)) || (dcount_w < len_w + CW'(2));
  assign fin_ok    = (dcount_w >= CW'(4)) && (dcount_w == len_w + CW'(4)) &&
                     (crc == got_crc) && (len_w + CW'(2) <= CW'(FRAME_CAPACITY));

  // staging bank is the one not committed
  assign fa_w      = dcount_w + (bank ? CW'(0) : CW'(FRAME_CAPACITY));
  assign frm_waddr = fa_w[FRM_AW-1:0];
  assign ra_w      = CW'(read_index) + (bank ? CW'(FRAME_CAPACITY) : CW'(0));
  assign frm_raddr = ra_w[FRM_AW-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ccfr_pkg::S_IDLE: begin
        if (accept) begin
          if (opcode == ccfr_pkg::OP_READ || wire_byte != 8'h00 ||
              overflow || raw_count == '0) begin
            state_next = ccfr_pkg::S_RESULT;
          end else begin
            state_next = ccfr_pkg::S_FETCH;
          end
        end
      end
      ccfr_pkg::S_FETCH: state_next = ccfr_pkg::S_USE;
      ccfr_pkg::S_USE: begin
        if (is_code && run_over) begin
          state_next = ccfr_pkg::S_RESULT;
        end else if (last_byte) begin
          state_next = ccfr_pkg::S_FINISH;
        end else begin
          state_next = ccfr_pkg::S_FETCH;
        end
      end
      ccfr_pkg::S_FINISH: state_next = ccfr_pkg::S_RESULT;
      ccfr_pkg::S_RESULT: begin
        if (slot_free) begin
          state_next = ccfr_pkg::S_IDLE;
        end
      end
      default: state_next = ccfr_pkg::S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    raw_we   = 1'b0;
    raw_re   = 1'b0;
    frm_re   = 1'b0;
    frm_we   = 1'b0;
    crc_init = 1'b0;
    crc_en   = 1'b0;
    emit     = 1'b0;
    unique case (state)
      ccfr_pkg::S_IDLE: begin
        if (accept) begin
          frm_re   = (opcode == ccfr_pkg::OP_READ);
          raw_we   = (opcode == ccfr_pkg::OP_FEED) && (wire_byte != 8'h00) && !overflow &&
                     (raw_count < RAW_CW'(RAW_CAPACITY));
          crc_init = 1'b1;
        end
      end
      ccfr_pkg::S_FETCH: raw_re = 1'b1;
      ccfr_pkg::S_USE: begin
        emit   = is_code ? (!first && !code_ff && !run_over) : 1'b1;
        crc_en = emit && in_crc;
        frm_we = emit && in_crc && (dcount_w < CW'(FRAME_CAPACITY));
      end
      ccfr_pkg::S_FINISH, ccfr_pkg::S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  ccfr_ram #(.WIDTH(8), .DEPTH(RAW_CAPACITY)) u_raw_ram (
    .clk   (clk),
    .we    (raw_we),
    .waddr (raw_count[RAW_AW-1:0]),
    .wdata (wire_byte),
    .re    (raw_re),
    .raddr (pos[RAW_AW-1:0]),
    .rdata (raw_rdata)
  );

  ccfr_ram #(.WIDTH(8), .DEPTH(FRM_DEPTH)) u_frame_ram (
    .clk   (clk),
    .we    (frm_we),
    .waddr (frm_waddr),
    .wdata (emit_byte),
    .re    (frm_re),
    .raddr (frm_raddr),
    .rdata (frm_rdata)
  );

  ccfr_crc u_crc (
    .clk  (clk),
    .init (crc_init),
    .en   (crc_en),
    .data (emit_byte),
    .crc  (crc)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ccfr_pkg::S_IDLE;
      raw_count        <= '0;
      overflow         <= 1'b0;
      committed_length <= '0;
      bank             <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (raw_we) begin
        raw_count <= raw_count + RAW_CW'(1);
      end
      if (accept && opcode == ccfr_pkg::OP_FEED) begin
        if (wire_byte != 8'h00) begin
          if (!overflow && raw_count >= RAW_CW'(RAW_CAPACITY)) begin
            overflow <= 1'b1;
          end
        end else if (overflow || raw_count == '0) begin
          raw_count <= '0;
          overflow  <= 1'b0;
        end
      end
      if (state == ccfr_pkg::S_USE && is_code && run_over) begin
        raw_count <= '0;
        overflow  <= 1'b0;
      end
      if (state == ccfr_pkg::S_FINISH) begin
        raw_count <= '0;
        overflow  <= 1'b0;
        if (fin_ok) begin
          bank             <= ~bank;
          committed_length <= 9'(len_w + CW'(2));
        end
      end
      if (state == ccfr_pkg::S_RESULT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      ccfr_pkg::S_IDLE: begin
        if (accept) begin
          pend_read <= (opcode == ccfr_pkg::OP_READ);
          pend_hit  <= (read_index < committed_length);
          pos       <= '0;
          dcount    <= '0;
          remain    <= 8'd0;
          first     <= 1'b1;
          code_ff   <= 1'b0;
          if (opcode == ccfr_pkg::OP_READ || wire_byte != 8'h00) begin
            pend_status <= ccfr_pkg::STAT_NEED_MORE;
          end else if (overflow) begin
            pend_status <= ccfr_pkg::STAT_DROP;
          end else if (raw_count == '0) begin
            pend_status <= ccfr_pkg::STAT_IDLE;
          end
        end
      end
      ccfr_pkg::S_USE: begin
        pos <= pos + RAW_CW'(1);
        if (is_code) begin
          if (run_over) begin
            pend_status <= ccfr_pkg::STAT_DROP;
          end
          remain  <= raw_rdata - 8'd1;
          code_ff <= (raw_rdata == 8'hFF);
          first   <= 1'b0;
        end else begin
          remain <= remain - 8'd1;
        end
        if (emit) begin
          dcount <= dcount + RAW_CW'(1);
          if (dcount_w == CW'(1)) begin
            len_r <= emit_byte;
          end
          if (!in_crc) begin
            if (dcount_w == len_w + CW'(2)) begin
              got_crc[7:0] <= emit_byte;
            end else if (dcount_w == len_w + CW'(3)) begin
              got_crc[15:8] <= emit_byte;
            end
          end
        end
      end
      ccfr_pkg::S_FINISH: begin
        pend_status <= fin_ok ? ccfr_pkg::STAT_READY : ccfr_pkg::STAT_DROP;
      end
      ccfr_pkg::S_RESULT: begin
        if (slot_free) begin
          status       <= pend_status;
          frame_length <= committed_length;
          read_data    <= (pend_read && pend_hit) ? frm_rdata : 8'h00;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/ccfr_ram.sv -----
`timescale 1ns / 1ps
module ccfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/ccfr_crc.sv -----
`timescale 1ns / 1ps
module ccfr_crc (
  input  logic        clk,
  input  logic        init,
  input  logic        en,
  input  logic [7:0]  data,
  output logic [15:0] crc
);

  always_ff @(posedge clk) begin
    if (init) begin
      crc <= ccfr_pkg::CRC_INIT;
    end else if (en) begin
      crc <= ccfr_pkg::crc_byte(crc, data);
    end
  end

endmodule

// ----- hdl/ccfr_checker.sv -----
`timescale 1ns / 1ps
`include "cobs_crc_frame_receiver_macros.svh"
module ccfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [8:0] frame_length,
  input logic [7:0] read_data
);

  `CCFR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(frame_length) && $stable(read_data))
  `CCFR_ASSERT_IMPLY(a_data_only_on_read, clk, rst, out_valid && read_data != 8'h00, status == ccfr_pkg::STAT_NEED_MORE)
  `CCFR_ASSERT_IMPLY(a_ready_has_header, clk, rst, out_valid && status == ccfr_pkg::STAT_READY, frame_length >= 9'd2)
  `CCFR_ASSERT_IMPLY(a_reset_empties_out, clk, 1'b0, $past(rst), !out_valid)
  `CCFR_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind cobs_crc_frame_receiver ccfr_checker u_ccfr_checker (.*);
